>>> hw/rtl/stp_pkg.sv
// shared types and codes of the software timer pool
package stp_pkg;

  localparam int unsigned MaxEntries = 32;

  // request codes on the action field
  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_FREE    = 3'd1,
    ACT_INIT    = 3'd2,
    ACT_SETTIME = 3'd3,
    ACT_TICK    = 3'd4
  } action_e;

  // result kinds
  typedef enum logic [2:0] {
    K_ALLOC_OK   = 3'd0,
    K_ALLOC_FAIL = 3'd1,
    K_ACK        = 3'd2,
    K_EXPIRED    = 3'd3,
    K_DONE       = 3'd4
  } kind_e;

  // classified command handed from front to back
  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_INIT    = 3'd2,
    OP_SETTIME = 3'd3,
    OP_TICK    = 3'd4,
    OP_NOP     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_RUN   = 2'd2
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  idx;
    logic [3:0]  queue;
    logic [7:0]  data;
    logic [31:0] timeout;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  entry;
    logic [3:0]  queue;
    logic [7:0]  data;
    logic [31:0] total;
    logic        last;
  } res_t;

endpackage

>>> hw/rtl/stp_front.sv
// request intake: decodes requests and holds them in a two-entry command queue
module stp_front #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    action_i,
  input  logic [4:0]    timer_index_i,
  input  logic [3:0]    dest_queue_i,
  input  logic [7:0]    event_data_i,
  input  logic [31:0]   timeout_i,
  output logic          cmd_valid_o,
  output stp_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import stp_pkg::*;

  localparam int unsigned Pool = (NUM_TIMERS < MaxEntries) ? NUM_TIMERS : MaxEntries;

  cmd_t       dec_cmd;
  logic       idx_ok;
  logic       push_ok;
  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign idx_ok = {1'b0, timer_index_i} < 6'(Pool);

  always_comb begin
    dec_cmd.idx     = timer_index_i;
    dec_cmd.queue   = dest_queue_i;
    dec_cmd.data    = event_data_i;
    dec_cmd.timeout = timeout_i;
    unique case (action_i)
      ACT_ALLOC:   dec_cmd.op = OP_ALLOC;
      ACT_FREE:    dec_cmd.op = idx_ok ? OP_FREE : OP_NOP;
      ACT_INIT:    dec_cmd.op = idx_ok ? OP_INIT : OP_NOP;
      ACT_SETTIME: dec_cmd.op = idx_ok ? OP_SETTIME : OP_NOP;
      ACT_TICK:    dec_cmd.op = OP_TICK;
      default:     dec_cmd.op = OP_NOP;
    endcase
  end

  assign full        = cnt_q == 2'd2;
  assign push_ok     = push && !full;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_ok;
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    cnt_d    = cnt_q + 2'(push_ok) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= dec_cmd;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("command queue count out of range");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_ok && !cmd_pop_i |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("command queue lost a transfer");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o) else $error("command popped from empty queue");
`endif

endmodule

>>> hw/rtl/stp_back.sv
// timer engine: entry table, tick walk and result register
module stp_back #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  stp_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty,
  input  logic          pop,
  output stp_pkg::res_t res_o
);
  import stp_pkg::*;

  localparam int unsigned Pool = (NUM_TIMERS < MaxEntries) ? NUM_TIMERS : MaxEntries;
  localparam int unsigned IdxW = (Pool > 1) ? $clog2(Pool) : 1;
  localparam logic [IdxW-1:0] WalkLast = IdxW'(Pool - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e          state_q, state_d;
  status_e         status_q [Pool];
  logic [31:0]     rem_q [Pool];
  logic [3:0]      queue_q [Pool];
  logic [7:0]      byte_q [Pool];
  logic [31:0]     tick_q, tick_d;
  logic [IdxW-1:0] walk_q, walk_d;
  logic            out_valid_q, out_valid_d;
  res_t            res_q, res_d;
  logic            res_we;

  logic            out_free;
  logic [IdxW-1:0] cmd_idx;
  logic [Pool-1:0] free_vec, lowest;
  logic            found;
  logic [IdxW-1:0] alloc_idx;
  logic            cur_run;
  logic [31:0]     rem_dec;
  logic            fire;

  logic            stat_we;
  logic [IdxW-1:0] stat_idx;
  status_e         stat_val;
  logic            rem_we;
  logic [IdxW-1:0] rem_idx;
  logic [31:0]     rem_val;
  logic            meta_we;

  assign out_free = !out_valid_q || pop;
  assign cmd_idx  = cmd_i.idx[IdxW-1:0];

  // lowest free entry: isolate the lowest set bit, then encode it
  always_comb begin
    for (int i = 0; i < Pool; i++) begin
      free_vec[i] = status_q[i] == ST_FREE;
    end
    lowest    = free_vec & (~free_vec + Pool'(1));
    found     = |free_vec;
    alloc_idx = '0;
    for (int i = 0; i < Pool; i++) begin
      if (lowest[i]) begin
        alloc_idx = alloc_idx | IdxW'(i);
      end
    end
  end

  assign cur_run = status_q[walk_q] == ST_RUN;
  assign rem_dec = rem_q[walk_q] - 32'd1;
  assign fire    = cur_run && (rem_dec == 32'd0);

  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    walk_d    = walk_q;
    cmd_pop_o = 1'b0;
    res_we    = 1'b0;
    res_d     = '{kind: K_ACK, entry: '0, queue: '0, data: '0, total: '0, last: 1'b1};
    stat_we   = 1'b0;
    stat_idx  = cmd_idx;
    stat_val  = ST_FREE;
    rem_we    = 1'b0;
    rem_idx   = cmd_idx;
    rem_val   = cmd_i.timeout;
    meta_we   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          res_we    = 1'b1;
          case (cmd_i.op)
            OP_ALLOC: begin
              if (found) begin
                stat_we    = 1'b1;
                stat_idx   = alloc_idx;
                stat_val   = ST_ALLOC;
                res_d.kind  = K_ALLOC_OK;
                res_d.entry = 5'(alloc_idx);
              end else begin
                res_d.kind = K_ALLOC_FAIL;
              end
            end
            OP_FREE: begin
              stat_we  = 1'b1;
              stat_val = ST_FREE;
            end
            OP_INIT: meta_we = 1'b1;
            OP_SETTIME: begin
              rem_we   = 1'b1;
              stat_we  = 1'b1;
              stat_val = ST_RUN;
            end
            OP_TICK: begin
              res_we  = 1'b0;
              tick_d  = tick_q + 32'd1;
              walk_d  = '0;
              state_d = S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        // a firing entry waits for the result slot, others pass straight on
        if (!fire || out_free) begin
          if (cur_run) begin
            rem_we  = 1'b1;
            rem_idx = walk_q;
            rem_val = rem_dec;
          end
          if (fire) begin
            stat_we     = 1'b1;
            stat_idx    = walk_q;
            stat_val    = ST_ALLOC;
            res_we      = 1'b1;
            res_d.kind  = K_EXPIRED;
            res_d.entry = 5'(walk_q);
            res_d.queue = queue_q[walk_q];
            res_d.data  = byte_q[walk_q];
            res_d.total = tick_q;
            res_d.last  = 1'b0;
          end
          if (walk_q == WalkLast) begin
            state_d = S_DONE;
          end else begin
            walk_d = walk_q + IdxW'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_we      = 1'b1;
          res_d.kind  = K_DONE;
          res_d.total = tick_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_we) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Pool; i++) begin
        status_q[i] <= ST_FREE;
      end
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
      if (stat_we) begin
        status_q[stat_idx] <= stat_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      rem_q[rem_idx] <= rem_val;
    end
    if (meta_we) begin
      queue_q[cmd_idx] <= cmd_i.queue;
      byte_q[cmd_idx]  <= cmd_i.data;
    end
    if (res_we) begin
      res_q <= res_d;
    end
  end

  assign empty = !out_valid_q;
  assign res_o = res_q;

`ifndef SYNTHESIS
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.last == (res_q.kind != K_EXPIRED)))
    else $error("last flag does not match result kind");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !cmd_pop_o) else $error("command taken during tick walk");
  a_tick_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && cmd_pop_o && cmd_i.op == OP_TICK
      |=> state_q == S_WALK && tick_q == $past(tick_q) + 32'd1)
    else $error("tick count not advanced on tick");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop |-> !res_we) else $error("waiting result overwritten");
`endif

endmodule

>>> hw/rtl/software_timer_pool_unit.sv
// top level of the software timer pool
//
// A pool of min(NUM_TIMERS, 32) countdown timers driven through a queue-style
// request port. Alloc, free, init and settime each give one result; a tick
// walks the entry table one entry per cycle, but waits at an expiring entry
// until the result side has taken the previous result. Up to two requests
// queue ahead of the engine, and a finished result sits in its own register,
// so requests keep being transferred while a result waits. Entry status is
// cleared at reset; the queue, byte and remaining count of an entry hold no
// value until written.
module software_timer_pool_unit #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  action_i,
  input  logic [4:0]  timer_index_i,
  input  logic [3:0]  dest_queue_i,
  input  logic [7:0]  event_data_i,
  input  logic [31:0] timeout_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [4:0]  entry_o,
  output logic [3:0]  out_queue_o,
  output logic [7:0]  out_data_o,
  output logic [31:0] tick_total_o,
  output logic        last_o
);
  import stp_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  stp_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .timer_index_i (timer_index_i),
    .dest_queue_i  (dest_queue_i),
    .event_data_i  (event_data_i),
    .timeout_i     (timeout_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  stp_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign kind_o       = res.kind;
  assign entry_o      = res.entry;
  assign out_queue_o  = res.queue;
  assign out_data_o   = res.data;
  assign tick_total_o = res.total;
  assign last_o       = res.last;

endmodule

>>> bench/testbench.sv
// self-checking testbench for the software timer pool unit
`timescale 1ns / 100ps

module testbench;
  import stp_pkg::*;

  localparam int unsigned NumTimers = 32;
  localparam int unsigned PoolSize = (NumTimers < 32) ? NumTimers : 32;
  localparam logic [2:0] ActRsvdFirst = 3'd5;
  localparam logic [2:0] ActRsvdLast = 3'd7;
  localparam int unsigned RandomItems = 110;
  localparam int unsigned PressureItems = 24;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned WatchdogLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  action_i = '0;
  logic [4:0]  timer_index_i = '0;
  logic [3:0]  dest_queue_i = '0;
  logic [7:0]  event_data_i = '0;
  logic [31:0] timeout_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind_o;
  logic [4:0]  entry_o;
  logic [3:0]  out_queue_o;
  logic [7:0]  out_data_o;
  logic [31:0] tick_total_o;
  logic        last_o;

  // pool state as the bench expects it
  status_e     pool_status[MaxEntries];
  logic [31:0] pool_left[MaxEntries];
  logic [3:0]  pool_queue[MaxEntries];
  logic [7:0]  pool_byte[MaxEntries];
  logic [31:0] pool_ticks;
  bit          ent_inited[MaxEntries];

  res_t        pending_results[$];
  res_t        got_res;
  res_t        want_res;
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_phase = 0;
  bit          hold_req = 1'b0;

  software_timer_pool_unit #(
    .NUM_TIMERS(NumTimers)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .timer_index_i(timer_index_i),
    .dest_queue_i (dest_queue_i),
    .event_data_i (event_data_i),
    .timeout_i    (timeout_i),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .entry_o      (entry_o),
    .out_queue_o  (out_queue_o),
    .out_data_o   (out_data_o),
    .tick_total_o (tick_total_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // work out the results of one accepted request and update the pool
  task automatic predict_request(input logic [2:0] act, input logic [4:0] idx,
                                 input logic [3:0] q, input logic [7:0] d,
                                 input logic [31:0] t);
    res_t r;
    res_t fired;
    bit   found;
    r = '0;
    r.kind = K_ACK;
    r.last = 1'b1;
    found = 1'b0;
    case (act)
      ACT_ALLOC: begin
        r.kind = K_ALLOC_FAIL;
        for (int i = 0; i < PoolSize; i++) begin
          if (!found && pool_status[i] == ST_FREE) begin
            pool_status[i] = ST_ALLOC;
            r.kind = K_ALLOC_OK;
            r.entry = 5'(i);
            found = 1'b1;
          end
        end
      end
      ACT_FREE: begin
        if (idx < PoolSize) pool_status[idx] = ST_FREE;
      end
      ACT_INIT: begin
        if (idx < PoolSize) begin
          pool_queue[idx] = q;
          pool_byte[idx] = d;
        end
      end
      ACT_SETTIME: begin
        if (idx < PoolSize) begin
          pool_left[idx] = t;
          pool_status[idx] = ST_RUN;
        end
      end
      ACT_TICK: begin
        pool_ticks = pool_ticks + 32'd1;
        for (int i = 0; i < PoolSize; i++) begin
          if (pool_status[i] == ST_RUN) begin
            pool_left[i] = pool_left[i] - 32'd1;
            if (pool_left[i] == 32'd0) begin
              pool_status[i] = ST_ALLOC;
              fired = '0;
              fired.kind = K_EXPIRED;
              fired.entry = 5'(i);
              fired.queue = pool_queue[i];
              fired.data = pool_byte[i];
              fired.total = pool_ticks;
              fired.last = 1'b0;
              pending_results.push_back(fired);
            end
          end
        end
        r.kind = K_DONE;
        r.total = pool_ticks;
      end
      default: ;
    endcase
    pending_results.push_back(r);
  endtask

  // request side monitor
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      predict_request(action_i, timer_index_i, dest_queue_i, event_data_i, timeout_i);
    end
  end

  // result side checker
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      got_res.kind = kind_e'(kind_o);
      got_res.entry = entry_o;
      got_res.queue = out_queue_o;
      got_res.data = out_data_o;
      got_res.total = tick_total_o;
      got_res.last = last_o;
      if (pending_results.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected result: kind %0d entry %0d queue %0h data %0h total %0d last %0b",
                   got_res.kind, got_res.entry, got_res.queue, got_res.data,
                   got_res.total, got_res.last);
        end
        fail_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.kind !== want_res.kind || got_res.entry !== want_res.entry ||
            got_res.queue !== want_res.queue || got_res.data !== want_res.data ||
            got_res.total !== want_res.total || got_res.last !== want_res.last) begin
          if (fail_count < 10) begin
            $display("mismatch at %0t: expected kind %0d entry %0d queue %0h data %0h total %0d last %0b",
                     $realtime, want_res.kind, want_res.entry, want_res.queue,
                     want_res.data, want_res.total, want_res.last);
            $display("                 got kind %0d entry %0d queue %0h data %0h total %0d last %0b",
                     got_res.kind, got_res.entry, got_res.queue, got_res.data,
                     got_res.total, got_res.last);
          end
          fail_count++;
        end
      end
    end
  end

  // receiver: stall pattern steps through four phases, long hold-off on request
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        case (rx_phase[8:7])
          2'd0: pop <= 1'b1;
          2'd1: pop <= ($urandom_range(0, 3) != 0);
          2'd2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= rx_phase[2];
        endcase
        rx_phase++;
      end
    end
  end

  // nothing transferred on either side for too long means a hang
  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("** software_timer_pool_unit: FAILED **");
    $finish;
  end

  // offer one request and return at the edge where it transfers
  task automatic send_item(input logic [2:0] act, input logic [4:0] idx,
                           input logic [3:0] q, input logic [7:0] d,
                           input logic [31:0] t);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    push <= 1'b1;
    action_i <= act;
    timer_index_i <= idx;
    dest_queue_i <= q;
    event_data_i <= d;
    timeout_i <= t;
    @(posedge clk_i);
    while (full !== 1'b0) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic test_directed();
    send_item(ACT_ALLOC, 5'd0, 4'h0, 8'h00, 32'd0);
    send_item(ACT_ALLOC, 5'd31, 4'hF, 8'hFF, 32'hFFFF_FFFF);
    send_item(ACT_INIT, 5'd0, 4'hF, 8'hFF, 32'd0);
    send_item(ACT_INIT, 5'd1, 4'h0, 8'h00, 32'hFFFF_FFFF);
    send_item(ACT_SETTIME, 5'd0, 4'h0, 8'h00, 32'd1);
    send_item(ACT_SETTIME, 5'd1, 4'hF, 8'hFF, 32'd2);
    send_item(ACT_TICK, 5'd0, 4'h0, 8'h00, 32'd0);
    send_item(ACT_TICK, 5'd31, 4'hF, 8'hFF, 32'hFFFF_FFFF);
    // zero timeout wraps and does not fire on the next tick
    send_item(ACT_SETTIME, 5'd1, 4'h3, 8'h3C, 32'd0);
    send_item(ACT_TICK, 5'd0, 4'h0, 8'h00, 32'd0);
    // free stops a running entry
    send_item(ACT_FREE, 5'd1, 4'h0, 8'h00, 32'd0);
    send_item(ACT_TICK, 5'd0, 4'h0, 8'h00, 32'd0);
    send_item(ACT_FREE, 5'd5, 4'h0, 8'h00, 32'd0);
    // settime on a free entry starts it
    send_item(ACT_INIT, 5'd7, 4'hA, 8'h5A, 32'd0);
    send_item(ACT_SETTIME, 5'd7, 4'h0, 8'h00, 32'd1);
    send_item(ACT_TICK, 5'd0, 4'h0, 8'h00, 32'd0);
    ent_inited[0] = 1'b1;
    ent_inited[1] = 1'b1;
    ent_inited[7] = 1'b1;
    for (int c = ActRsvdFirst; c <= ActRsvdLast; c++) begin
      send_item(3'(c), 5'($urandom), 4'($urandom), 8'($urandom), $urandom);
    end
    send_item(ACT_SETTIME, 5'd0, 4'h0, 8'h00, 32'hFFFF_FFFF);
    send_item(ACT_ALLOC, 5'd0, 4'h0, 8'h00, 32'd0);
    send_item(ACT_FREE, 5'd0, 4'h0, 8'h00, 32'd0);
    send_item(ACT_ALLOC, 5'd0, 4'h0, 8'h00, 32'd0);
  endtask

  // fill the pool, then fire every entry on one tick
  task automatic test_pool_exhaust();
    for (int i = 0; i <= PoolSize; i++) begin
      send_item(ACT_ALLOC, 5'($urandom), 4'($urandom), 8'($urandom), $urandom);
    end
    for (int i = 0; i < PoolSize; i++) begin
      send_item(ACT_INIT, 5'(i), 4'($urandom), 8'($urandom), $urandom);
      ent_inited[i] = 1'b1;
    end
    for (int i = 0; i < PoolSize; i++) begin
      send_item(ACT_SETTIME, 5'(i), 4'($urandom), 8'($urandom), 32'd1);
    end
    send_item(ACT_TICK, 5'($urandom), 4'($urandom), 8'($urandom), $urandom);
    send_item(ACT_TICK, 5'($urandom), 4'($urandom), 8'($urandom), $urandom);
  endtask

  // result side held off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int n = 0; n < PressureItems; n++) begin
      if (n % 3 == 2) begin
        send_item(ACT_TICK, 5'($urandom), 4'($urandom), 8'($urandom), $urandom);
      end else begin
        send_item(ACT_SETTIME, 5'($urandom), 4'($urandom), 8'($urandom),
                  $urandom_range(1, 3));
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned sel;
    logic [4:0]  idx;
    logic [31:0] t;
    for (int n = 0; n < RandomItems; n++) begin
      sel = $urandom_range(0, 99);
      idx = 5'($urandom);
      if (sel < 12) begin
        send_item(ACT_ALLOC, idx, 4'($urandom), 8'($urandom), $urandom);
      end else if (sel < 25) begin
        send_item(ACT_FREE, idx, 4'($urandom), 8'($urandom), $urandom);
      end else if (sel < 40) begin
        send_item(ACT_INIT, idx, 4'($urandom), 8'($urandom), $urandom);
        ent_inited[idx] = 1'b1;
      end else if (sel < 75) begin
        // an entry must carry queue and byte before it can fire
        if (!ent_inited[idx]) begin
          send_item(ACT_INIT, idx, 4'($urandom), 8'($urandom), $urandom);
          ent_inited[idx] = 1'b1;
        end
        sel = $urandom_range(0, 99);
        if (sel < 80) t = $urandom_range(1, 6);
        else if (sel < 88) t = 32'd0;
        else if (sel < 96) t = $urandom;
        else t = 32'hFFFF_FFFF;
        send_item(ACT_SETTIME, idx, 4'($urandom), 8'($urandom), t);
      end else if (sel < 97) begin
        send_item(ACT_TICK, idx, 4'($urandom), 8'($urandom), $urandom);
      end else begin
        send_item(3'($urandom_range(ActRsvdFirst, ActRsvdLast)), idx, 4'($urandom),
                  8'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MaxEntries; i++) begin
      pool_status[i] = ST_FREE;
      pool_left[i] = '0;
      pool_queue[i] = '0;
      pool_byte[i] = '0;
      ent_inited[i] = 1'b0;
    end
    pool_ticks = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pool_exhaust();
    test_backpressure();
    test_random_traffic();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** software_timer_pool_unit: PASSED **");
    end else begin
      $display("** software_timer_pool_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/stp_pkg.sv
hw/rtl/stp_front.sv
hw/rtl/stp_back.sv
hw/rtl/software_timer_pool_unit.sv
bench/testbench.sv
